[rtl/bitmap_font_text_renderer_core_macros.svh]
// Assertion macros used by the checker file of the text renderer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BITMAP_FONT_TEXT_RENDERER_CORE_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bfr_pkg.sv]
// Types and constants of the bitmap font text renderer.
// Used by the front, queue, back and top-level modules; no dependencies.
package bfr_pkg;

  localparam int STORE_DEPTH = 8192;
  localparam int STORE_AW    = 13;
  localparam int ROW_STRIDE  = 32;
  localparam int ROW_BITS    = 5;
  localparam int QDEPTH      = 4;

  localparam logic [7:0] CODE_CR = 8'd13;
  localparam logic [7:0] CODE_LF = 8'd10;

  localparam logic [3:0]  RST_GLYPH_WIDTH  = 4'd8;
  localparam logic [5:0]  RST_GLYPH_HEIGHT = 6'd16;
  localparam logic [8:0]  RST_GLYPH_COUNT  = 9'd256;
  localparam logic [15:0] RST_PITCH_BYTES  = 16'd2560;
  localparam logic [31:0] RST_DRAW_COLOR   = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_DRAW   = 2'd1,
    FUNC_CURSOR = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_GLYPH_COUNT  = 3'd2,
    REG_PITCH_BYTES  = 3'd3,
    REG_DRAW_COLOR   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_NOTE = 2'd0,
    OP_LOAD = 2'd1,
    OP_DRAW = 2'd2
  } op_t;

  typedef struct packed {
    logic [3:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [8:0]  glyph_count;
    logic [15:0] pitch_bytes;
    logic [31:0] draw_color;
  } cfg_t;

  typedef struct packed {
    op_t                 op;
    logic [STORE_AW-1:0] font_address;
    logic [7:0]          font_byte;
    logic [5:0]          rows;
    logic [7:0]          pmask;
    logic [31:0]         base;
    logic [15:0]         cursor_x;
    logic [15:0]         cursor_y;
  } cmd_t;

  function automatic logic [7:0] width_mask(input logic [3:0] w);
    logic [8:0] m;
    m = (9'd1 << w) - 9'd1;
    return m[7:0];
  endfunction

  function automatic logic [7:0] bit_reverse(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

[rtl/bfr_queue.sv]
// Command queue between the front and back of the text renderer.
// Small register FIFO of cmd_t entries; depends on bfr_pkg.
module bfr_queue
  import bfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int QAW = $clog2(QDEPTH);

  cmd_t             entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != (QAW+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/bfr_front.sv]
// Front of the text renderer: accepts items, tracks the cursor, classifies
// each item into a command and computes the glyph base offset; uses bfr_pkg.
module bfr_front
  import bfr_pkg::*;
#(
  parameter int MAX_GLYPHS = 256,
  parameter int MAX_ROWS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [12:0] font_address,
  input  logic [7:0]  font_byte,
  input  logic [7:0]  char_code,
  input  logic [15:0] new_x,
  input  logic [15:0] new_y,
  output logic        push_valid,
  input  logic        push_ready,
  output cmd_t        push_data
);

  localparam int         HCAP      = (MAX_ROWS < ROW_STRIDE) ? MAX_ROWS : ROW_STRIDE;
  localparam logic [5:0] HCAP6     = 6'(HCAP);
  localparam logic [8:0] GLYPH_CAP = 9'(MAX_GLYPHS);

  logic [15:0] cursor_x;
  logic [15:0] cursor_y;
  logic [15:0] cursor_x_next;
  logic [15:0] cursor_y_next;

  logic        s1_valid;
  cmd_t        s1_cmd;
  logic [15:0] s1_x_old;
  logic [15:0] s1_y_old;
  logic        s2_valid;
  cmd_t        s2_cmd;
  logic [31:0] s2_prod;
  logic [17:0] s2_x4;

  cmd_t        cmd_next;
  logic [3:0]  w;
  logic [5:0]  h;
  logic [7:0]  glyph;
  logic        accept;
  logic        s1_move;
  logic        s2_move;

  assign s2_move  = s2_valid && push_ready;
  assign s1_move  = s1_valid && (!s2_valid || s2_move);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    w = (cfg.glyph_width > 4'd8) ? 4'd8 : cfg.glyph_width;
    h = (cfg.glyph_height > HCAP6) ? HCAP6 : cfg.glyph_height;
    glyph = (({1'b0, char_code} < cfg.glyph_count) && ({1'b0, char_code} < GLYPH_CAP))
            ? char_code : 8'd0;
    cmd_next = '0;
    cmd_next.op = OP_NOTE;
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    unique case (func_t'(func))
      FUNC_LOAD: begin
        cmd_next.op = OP_LOAD;
        cmd_next.font_address = font_address;
        cmd_next.font_byte = font_byte;
      end
      FUNC_CURSOR: begin
        cursor_x_next = new_x;
        cursor_y_next = new_y;
      end
      FUNC_DRAW: begin
        if (char_code == CODE_CR) begin
          cursor_x_next = '0;
        end else if (char_code == CODE_LF) begin
          cursor_x_next = '0;
          cursor_y_next = cursor_y + {10'd0, cfg.glyph_height};
        end else begin
          cursor_x_next = cursor_x + {12'd0, w} + 16'd1;
          if (h != 6'd0) begin
            cmd_next.op = OP_DRAW;
            cmd_next.font_address = {glyph, ROW_BITS'(0)};
            cmd_next.rows = h;
            cmd_next.pmask = width_mask(w);
          end
        end
      end
      default: begin
      end
    endcase
    cmd_next.cursor_x = cursor_x_next;
    cmd_next.cursor_y = cursor_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd_next;
      s1_x_old <= cursor_x;
      s1_y_old <= cursor_y;
    end
    if (s1_move) begin
      s2_cmd  <= s1_cmd;
      s2_prod <= s1_y_old * cfg.pitch_bytes;
      s2_x4   <= {s1_x_old, 2'b00};
    end
  end

  always_comb begin
    push_data = s2_cmd;
    push_data.base = s2_prod + {14'd0, s2_x4};
  end

  assign push_valid = s2_valid;

endmodule

[rtl/bfr_back.sv]
// Back of the text renderer: runs queued commands, owns the font store and
// emits one result per row or event through an output register; uses bfr_pkg.
module bfr_back
  import bfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic [31:0] byte_offset,
  output logic [7:0]  pixel_mask,
  output logic [31:0] color,
  output logic [15:0] cursor_x,
  output logic [15:0] cursor_y,
  output logic        last
);

  logic [7:0]          store [STORE_DEPTH];
  logic [7:0]          rdata;

  logic                cur_valid;
  cmd_t                cur;
  logic [ROW_BITS-1:0] cur_row;
  logic [31:0]         cur_off;
  logic                cur_last;

  logic                rd_valid;
  logic                rd_write;
  logic [31:0]         rd_off;
  logic [7:0]          rd_pmask;
  logic [15:0]         rd_x;
  logic [15:0]         rd_y;
  logic                rd_last;

  logic                out_load;
  logic                issue_ok;
  logic                go;
  logic                pop;
  logic                mem_re;
  logic                mem_we;

  assign out_load = rd_valid && (!out_valid || !out_stall);
  assign issue_ok = !rd_valid || out_load;
  assign go       = cur_valid && issue_ok;
  assign cur_last = (cur.op != OP_DRAW) || ({1'b0, cur_row} == (cur.rows - 6'd1));
  assign pop      = q_valid && (!cur_valid || (go && cur_last));
  assign q_ready  = pop;
  assign mem_re   = go && (cur.op == OP_DRAW);
  assign mem_we   = go && (cur.op == OP_LOAD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[cur.font_address] <= cur.font_byte;
    end
    if (mem_re) begin
      rdata <= store[{cur.font_address[STORE_AW-1:ROW_BITS], cur_row}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (go && cur_last) begin
        cur_valid <= 1'b0;
      end
      if (go) begin
        rd_valid <= 1'b1;
      end else if (out_load) begin
        rd_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= q_data;
      cur_row <= '0;
      cur_off <= q_data.base;
    end else if (go) begin
      cur_row <= cur_row + ROW_BITS'(1);
      cur_off <= cur_off + {16'd0, cfg.pitch_bytes};
    end
    if (go) begin
      rd_write <= (cur.op == OP_DRAW);
      rd_off   <= (cur.op == OP_DRAW) ? cur_off : 32'd0;
      rd_pmask <= cur.pmask;
      rd_x     <= cur.cursor_x;
      rd_y     <= cur.cursor_y;
      rd_last  <= cur_last;
    end
    if (out_load) begin
      write_valid <= rd_write;
      byte_offset <= rd_off;
      pixel_mask  <= rd_write ? (bit_reverse(rdata) & rd_pmask) : 8'd0;
      color       <= rd_write ? cfg.draw_color : 32'd0;
      cursor_x    <= rd_x;
      cursor_y    <= rd_y;
      last        <= rd_last;
    end
  end

endmodule

[rtl/bitmap_font_text_renderer_core.sv]
// A drawn character gives one result per glyph row, with one font store read
// per cycle while the output is not stalled; every other item gives one
// result. The queue lets the front run ahead. Reset clears cursor and
// pipeline, restores register defaults and leaves the font store as it was.
module bitmap_font_text_renderer_core
  import bfr_pkg::*;
#(
  parameter int MAX_GLYPHS = 256,
  parameter int MAX_ROWS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [12:0] font_address,
  input  logic [7:0]  font_byte,
  input  logic [7:0]  char_code,
  input  logic [15:0] new_x,
  input  logic [15:0] new_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_valid,
  output logic [31:0] byte_offset,
  output logic [7:0]  pixel_mask,
  output logic [31:0] color,
  output logic [15:0] cursor_x,
  output logic [15:0] cursor_y,
  output logic        last
);

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic q_valid;
  logic q_ready;
  cmd_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width  <= RST_GLYPH_WIDTH;
      cfg.glyph_height <= RST_GLYPH_HEIGHT;
      cfg.glyph_count  <= RST_GLYPH_COUNT;
      cfg.pitch_bytes  <= RST_PITCH_BYTES;
      cfg.draw_color   <= RST_DRAW_COLOR;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[3:0];
        REG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[5:0];
        REG_GLYPH_COUNT:  cfg.glyph_count  <= cfg_data[8:0];
        REG_PITCH_BYTES:  cfg.pitch_bytes  <= cfg_data[15:0];
        REG_DRAW_COLOR:   cfg.draw_color   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bfr_front #(
    .MAX_GLYPHS(MAX_GLYPHS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .font_address(font_address),
    .font_byte   (font_byte),
    .char_code   (char_code),
    .new_x       (new_x),
    .new_y       (new_y),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  bfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  bfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .write_valid(write_valid),
    .byte_offset(byte_offset),
    .pixel_mask (pixel_mask),
    .color      (color),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .last       (last)
  );

endmodule

[rtl/bfr_checker.sv]
// Port-level checks for the text renderer, bound to the top level.
// Depends on bitmap_font_text_renderer_core_macros.svh.
`include "bitmap_font_text_renderer_core_macros.svh"

module bfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  func,
  input logic [12:0] font_address,
  input logic [7:0]  font_byte,
  input logic [7:0]  char_code,
  input logic [15:0] new_x,
  input logic [15:0] new_y,
  input logic        out_valid,
  input logic        out_stall,
  input logic        write_valid,
  input logic [31:0] byte_offset,
  input logic [7:0]  pixel_mask,
  input logic [31:0] color,
  input logic [15:0] cursor_x,
  input logic [15:0] cursor_y,
  input logic        last
);

  `BFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(byte_offset) && $stable(pixel_mask) && $stable(last), "stalled result changed")

  `BFR_ASSERT_NOW(a_note_zero, out_valid && !write_valid, byte_offset == 32'd0 && pixel_mask == 8'd0 && color == 32'd0 && last, "non-write result not zero or not last")

  `BFR_ASSERT_NEXT(a_row_cursor, out_valid && write_valid && !last && !out_stall, !out_valid || (write_valid && cursor_x == $past(cursor_x) && cursor_y == $past(cursor_y)), "glyph rows of one item disagree")

endmodule

bind bitmap_font_text_renderer_core bfr_checker u_bfr_checker (.*);
